[src/vlra_pkg.sv]
// Shared request codes, status codes and sequencer states of the ring allocator.
package vlra_pkg;

  // Request kinds carried on req_type.
  localparam logic [2:0] REQ_ALLOC   = 3'd0;
  localparam logic [2:0] REQ_COMMIT  = 3'd1;
  localparam logic [2:0] REQ_ABANDON = 3'd2;
  localparam logic [2:0] REQ_LOCK    = 3'd3;
  localparam logic [2:0] REQ_DONE    = 3'd4;
  localparam logic [2:0] REQ_ABORT   = 3'd5;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_LOCKED    = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_NOT_READY = 3'd4;
  localparam logic [2:0] ST_NO_SPACE  = 3'd5;
  localparam logic [2:0] ST_NO_SLOT   = 3'd6;
  localparam logic [2:0] ST_IGNORED   = 3'd7;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_AL_HEAD,
    S_AL_LAST,
    S_AL_FIT,
    S_LK_READ,
    S_LK_CHECK,
    S_MOD,
    S_RESULT
  } state_t;

endpackage

[src/vlra_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module vlra_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/variable_length_ring_allocator.sv]
// Top level of the variable-length ring allocator: sequencer, state registers and APB registers.
//
// This block keeps a byte area as a ring of contiguous variable-length buffers, tracked by a
// ring of descriptor slots from the head (oldest) to the tail (next free). It takes one request
// at a time on the input channel and answers each with exactly one result on the output
// channel; the next request is accepted while the previous result still waits to be taken.
// A request is carried out by a small sequencer that drives one shared compare-and-subtract
// unit and one read port of the descriptor memories (offset, length and ready flag, each a
// registered-read RAM). Every request passes through the accepting idle state, an execute
// state and the result state; commit, abandon, done without release and ignored requests need
// nothing more. Done with release and abort add the slot wrap step. Allocate goes straight to
// the result when rejected early, to the fit state and the slot wrap step on an empty ring,
// and otherwise reads the head and newest descriptors before the fit state, plus the slot wrap
// step when it succeeds. Lock goes straight to the result when refused, stops at its read state
// on an empty ring, else examines the head buffer; for every empty ready dummy it reaps at the
// head it takes the slot wrap step and reads the next head descriptor. The slot wrap step
// (advancing head or tail modulo the ring size) is done by repeated subtraction in the shared
// unit, which subtracts more than once only after descriptor_count was lowered while slots
// were in use. A result that cannot enter the output register because the previous result is
// still stalled there keeps the sequencer in its result state. The descriptor memories have no
// reset and need no clearing pass; the block accepts requests once reset has set it idle.
// Configuration (area_length at byte address 0, descriptor_count at byte address 4) must be
// written through the APB port only while idle; the block itself does not enforce this.
module variable_length_ring_allocator
  import vlra_pkg::*;
#(
  parameter int MAX_SLOTS = 16,
  parameter int unsigned AREA_BYTES = 65535
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [15:0] request_length,
  input  logic [3:0]  slot_index,
  input  logic [7:0]  consumer_count,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [3:0]  granted_slot,
  output logic [15:0] buffer_offset,
  output logic [15:0] buffer_length,
  output logic        ready_event,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // descriptor_count is 5 bits wide, so the ring never holds more than 31 slots.
  localparam int RMAX = (MAX_SLOTS < 31) ? MAX_SLOTS : 31;
  localparam int SW   = $clog2(RMAX);
  localparam int UW   = $clog2(RMAX + 1);

  // Configuration registers.
  logic [15:0] area_length;
  logic [4:0]  descriptor_count;

  // Sequencer and allocator state.
  state_t state, state_next;
  logic [SW-1:0] head, head_next;
  logic [SW-1:0] tail, tail_next;
  logic [UW-1:0] used, used_next;
  logic          lock_held, lock_held_next;
  logic [7:0]    pending_acks, pending_acks_next;

  // Latched request.
  logic [2:0]  rq_type, rq_type_next;
  logic [15:0] rq_len, rq_len_next;
  logic [3:0]  rq_idx, rq_idx_next;
  logic [7:0]  rq_cc, rq_cc_next;

  // Allocation work registers.
  logic [15:0] first_off, first_off_next;
  logic [15:0] last_off, last_off_next;
  logic [16:0] newest_end, newest_end_next;

  // Slot wrap unit: the value being reduced, which pointer it updates, and where to go after.
  logic [4:0] mod_val, mod_val_next;
  logic       mod_head, mod_head_next;
  logic       mod_lock, mod_lock_next;

  // Result being built.
  logic [2:0]  res_status, res_status_next;
  logic [3:0]  res_slot, res_slot_next;
  logic [15:0] res_off, res_off_next;
  logic [15:0] res_len, res_len_next;
  logic        res_ev, res_ev_next;

  // Descriptor memory ports.
  logic [SW-1:0] rd_addr, wr_addr;
  logic          off_we, len_we, rdy_we;
  logic [15:0]   off_wdata, len_wdata, rd_off, rd_len;
  logic          rdy_wdata, rd_rdy;

  // Derived values.
  logic [15:0]   alen;
  logic [4:0]    ring;
  logic [SW-1:0] last_slot;
  logic [UW-1:0] used_dec;
  logic [7:0]    pend_dec;
  logic          alloc_bad, ring_full, idx_bad, idx_is_last, used_zero;
  logic          in_order, fits, wrap_ok, place_ok, mod_ge, reap, out_load;
  logic [15:0]   bound, place_at;
  logic [17:0]   end_sum;
  logic          cfg_wr;

  // The area size is clamped to AREA_BYTES, the ring size to 1..RMAX.
  assign alen = ({16'd0, area_length} > 32'(AREA_BYTES)) ? 16'(AREA_BYTES) : area_length;
  assign ring = (descriptor_count == 5'd0) ? 5'd1 :
                ((descriptor_count > 5'(RMAX)) ? 5'(RMAX) : descriptor_count);

  assign last_slot   = (tail == '0) ? SW'(ring - 5'd1) : tail - 1'b1;
  assign used_zero   = (used == '0);
  assign used_dec    = used_zero ? used : used - 1'b1;
  assign pend_dec    = (pending_acks != 8'd0) ? pending_acks - 8'd1 : 8'd0;
  assign alloc_bad   = (rq_len == 16'd0) || (rq_len > alen);
  assign ring_full   = (5'(used) >= ring);
  assign idx_bad     = (5'(rq_idx) >= ring);
  assign idx_is_last = (5'(rq_idx) == 5'(last_slot));

  // Placement after the newest buffer: the shared adder forms newest_end + length and compares
  // it with the end of the area (buffers in order) or with the oldest buffer (wrapped ring).
  assign in_order = (last_off >= first_off);
  assign bound    = in_order ? alen : first_off;
  assign end_sum  = {1'b0, newest_end} + 18'(rq_len);
  assign fits     = (end_sum <= {2'b00, bound});
  assign wrap_ok  = in_order && (first_off >= rq_len);
  assign place_ok = used_zero || fits || wrap_ok;
  assign place_at = (used_zero || !fits) ? 16'd0 : newest_end[15:0];

  assign mod_ge   = (mod_val >= ring);
  assign reap     = rd_rdy && (rd_len == 16'd0);
  assign out_load = (state == S_RESULT) && (!out_valid || !out_stall);

  assign in_stall = (state != S_IDLE);
  assign rd_addr  = (state == S_AL_HEAD) ? last_slot : head;

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (rq_type)
          REQ_ALLOC: begin
            if (alloc_bad || ring_full) state_next = S_RESULT;
            else if (used_zero)         state_next = S_AL_FIT;
            else                        state_next = S_AL_HEAD;
          end
          REQ_LOCK: begin
            if (lock_held || rq_cc == 8'd0) state_next = S_RESULT;
            else                             state_next = S_LK_READ;
          end
          REQ_DONE: begin
            if (lock_held && pend_dec == 8'd0) state_next = S_MOD;
            else                               state_next = S_RESULT;
          end
          REQ_ABORT: begin
            if (lock_held) state_next = S_MOD;
            else           state_next = S_RESULT;
          end
          default: state_next = S_RESULT;
        endcase
      end
      S_AL_HEAD: state_next = S_AL_LAST;
      S_AL_LAST: state_next = S_AL_FIT;
      S_AL_FIT: begin
        if (place_ok) state_next = S_MOD;
        else          state_next = S_RESULT;
      end
      S_LK_READ: begin
        if (used_zero) state_next = S_RESULT;
        else           state_next = S_LK_CHECK;
      end
      S_LK_CHECK: begin
        if (reap) state_next = S_MOD;
        else      state_next = S_RESULT;
      end
      S_MOD: begin
        if (!mod_ge) state_next = mod_lock ? S_LK_READ : S_RESULT;
      end
      S_RESULT: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Register updates and memory controls for each sequencer state.
  always_comb begin
    head_next         = head;
    tail_next         = tail;
    used_next         = used;
    lock_held_next    = lock_held;
    pending_acks_next = pending_acks;
    rq_type_next      = rq_type;
    rq_len_next       = rq_len;
    rq_idx_next       = rq_idx;
    rq_cc_next        = rq_cc;
    first_off_next    = first_off;
    last_off_next     = last_off;
    newest_end_next   = newest_end;
    mod_val_next      = mod_val;
    mod_head_next     = mod_head;
    mod_lock_next     = mod_lock;
    res_status_next   = res_status;
    res_slot_next     = res_slot;
    res_off_next      = res_off;
    res_len_next      = res_len;
    res_ev_next       = res_ev;
    wr_addr           = tail;
    off_we            = 1'b0;
    len_we            = 1'b0;
    rdy_we            = 1'b0;
    off_wdata         = place_at;
    len_wdata         = rq_len;
    rdy_wdata         = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          rq_type_next    = req_type;
          rq_len_next     = request_length;
          rq_idx_next     = slot_index;
          rq_cc_next      = consumer_count;
          res_status_next = ST_IGNORED;
          res_slot_next   = 4'd0;
          res_off_next    = 16'd0;
          res_len_next    = 16'd0;
          res_ev_next     = 1'b0;
        end
      end
      S_EXEC: begin
        case (rq_type)
          REQ_ALLOC: begin
            if (alloc_bad)      res_status_next = ST_INVALID;
            else if (ring_full) res_status_next = ST_NO_SLOT;
          end
          REQ_COMMIT: begin
            if (idx_bad) begin
              res_status_next = ST_INVALID;
            end else begin
              wr_addr         = SW'(rq_idx);
              rdy_we          = 1'b1;
              rdy_wdata       = 1'b1;
              res_status_next = ST_OK;
              res_ev_next     = 1'b1;
            end
          end
          REQ_ABANDON: begin
            if (idx_bad) begin
              res_status_next = ST_INVALID;
            end else if (used_zero) begin
              res_status_next = ST_IGNORED;
            end else if (idx_is_last) begin
              // Roll back the newest buffer.
              tail_next       = last_slot;
              used_next       = used_dec;
              res_status_next = ST_OK;
            end else begin
              // An older buffer becomes an empty ready dummy for lock to reap.
              wr_addr         = SW'(rq_idx);
              len_we          = 1'b1;
              len_wdata       = 16'd0;
              rdy_we          = 1'b1;
              rdy_wdata       = 1'b1;
              res_status_next = ST_OK;
            end
          end
          REQ_LOCK: begin
            if (lock_held)              res_status_next = ST_LOCKED;
            else if (rq_cc == 8'd0)     res_status_next = ST_INVALID;
          end
          REQ_DONE: begin
            if (lock_held) begin
              pending_acks_next = pend_dec;
              res_status_next   = ST_OK;
              if (pend_dec == 8'd0) begin
                lock_held_next = 1'b0;
                used_next      = used_dec;
                mod_val_next   = 5'(head) + 5'd1;
                mod_head_next  = 1'b1;
                mod_lock_next  = 1'b0;
              end
            end
          end
          REQ_ABORT: begin
            if (lock_held) begin
              pending_acks_next = 8'd0;
              lock_held_next    = 1'b0;
              used_next         = used_dec;
              mod_val_next      = 5'(head) + 5'd1;
              mod_head_next     = 1'b1;
              mod_lock_next     = 1'b0;
              res_status_next   = ST_OK;
            end
          end
          default: ;
        endcase
      end
      S_AL_HEAD: begin
        first_off_next = rd_off;
      end
      S_AL_LAST: begin
        last_off_next   = rd_off;
        newest_end_next = {1'b0, rd_off} + {1'b0, rd_len};
      end
      S_AL_FIT: begin
        if (place_ok) begin
          off_we          = 1'b1;
          len_we          = 1'b1;
          rdy_we          = 1'b1;
          res_status_next = ST_OK;
          res_slot_next   = 4'(tail);
          res_off_next    = place_at;
          used_next       = used + 1'b1;
          mod_val_next    = 5'(tail) + 5'd1;
          mod_head_next   = 1'b0;
          mod_lock_next   = 1'b0;
        end else begin
          res_status_next = ST_NO_SPACE;
        end
      end
      S_LK_READ: begin
        if (used_zero) res_status_next = ST_EMPTY;
      end
      S_LK_CHECK: begin
        if (reap) begin
          used_next     = used_dec;
          mod_val_next  = 5'(head) + 5'd1;
          mod_head_next = 1'b1;
          mod_lock_next = 1'b1;
        end else if (!rd_rdy) begin
          res_status_next = ST_NOT_READY;
        end else begin
          res_status_next   = ST_OK;
          res_off_next      = rd_off;
          res_len_next      = rd_len;
          lock_held_next    = 1'b1;
          pending_acks_next = rq_cc;
        end
      end
      S_MOD: begin
        if (mod_ge) begin
          mod_val_next = mod_val - ring;
        end else if (mod_head) begin
          head_next = SW'(mod_val);
        end else begin
          tail_next = SW'(mod_val);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      tail         <= '0;
      used         <= '0;
      lock_held    <= 1'b0;
      pending_acks <= 8'd0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      head         <= head_next;
      tail         <= tail_next;
      used         <= used_next;
      lock_held    <= lock_held_next;
      pending_acks <= pending_acks_next;
      if (out_load)        out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rq_type    <= rq_type_next;
    rq_len     <= rq_len_next;
    rq_idx     <= rq_idx_next;
    rq_cc      <= rq_cc_next;
    first_off  <= first_off_next;
    last_off   <= last_off_next;
    newest_end <= newest_end_next;
    mod_val    <= mod_val_next;
    mod_head   <= mod_head_next;
    mod_lock   <= mod_lock_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_off    <= res_off_next;
    res_len    <= res_len_next;
    res_ev     <= res_ev_next;
    if (out_load) begin
      status        <= res_status;
      granted_slot  <= res_slot;
      buffer_offset <= res_off;
      buffer_length <= res_len;
      ready_event   <= res_ev;
    end
  end

  // Configuration registers; the word address selects the register.
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {27'd0, descriptor_count} : {16'd0, area_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      area_length      <= 16'd65535;
      descriptor_count <= 5'd16;
    end else if (cfg_wr) begin
      if (paddr[2]) descriptor_count <= pwdata[4:0];
      else          area_length      <= pwdata[15:0];
    end
  end

  // Descriptor stores: one RAM per field, sharing the read and write addresses.
  vlra_ram #(.WIDTH(16), .DEPTH(RMAX)) u_off_ram (
    .clk   (clk),
    .we    (off_we),
    .waddr (wr_addr),
    .wdata (off_wdata),
    .raddr (rd_addr),
    .rdata (rd_off)
  );

  vlra_ram #(.WIDTH(16), .DEPTH(RMAX)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (wr_addr),
    .wdata (len_wdata),
    .raddr (rd_addr),
    .rdata (rd_len)
  );

  vlra_ram #(.WIDTH(1), .DEPTH(RMAX)) u_rdy_ram (
    .clk   (clk),
    .we    (rdy_we),
    .waddr (wr_addr),
    .wdata (rdy_wdata),
    .raddr (rd_addr),
    .rdata (rd_rdy)
  );

endmodule
